@@ design/gef_pkg.sv @@
`timescale 1ns / 1ps

package gef_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    // Signed range of one gradient sum is -1020..1020.
    localparam int GRAD_W     = 11;
    // |gx| + |gy| reaches at most 2040.
    localparam int MAG_W      = 12;

    typedef logic [PIX_W-1:0] pix_t;

    localparam logic [CFG_IDX_W-1:0] CFG_OPERATOR_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RESET_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] RESET_FRAME_HEIGHT = 11'd480;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic MODE_SOBEL   = 1'b0;
    localparam logic MODE_PREWITT = 1'b1;

    // Control for one beat as it moves from the position stage to the window stage.
    typedef struct packed {
        logic produce;    // this beat completes a result
        logic shift;      // result for the last column of the previous row
        logic mask_top;   // window row above is outside the frame
        logic mask_bot;   // window row below is outside the frame
        logic mask_left;  // window column on the left is outside the frame
        logic frame_end;  // result for the last pixel of the frame
    } step_ctrl_t;

    typedef struct packed {
        logic frame_end;
        pix_t magnitude;
        pix_t grad_y;
        pix_t grad_x;
    } result_t;

endpackage

@@ design/gef_sdp_ram.sv @@
`timescale 1ns / 1ps

module gef_sdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/gef_line_buf.sv @@
`timescale 1ns / 1ps

module gef_line_buf #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  gef_pkg::pix_t                wr_pixel,
    output gef_pkg::pix_t                upper_pixel,
    output gef_pkg::pix_t                lower_pixel
);

    import gef_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    pix_t ram_upper_q;
    pix_t ram_lower_q;
    logic byp_reg;
    logic byp_next;
    pix_t byp_upper_reg;
    pix_t byp_lower_reg;

    // The upper store takes over what the lower store held at that column.
    gef_sdp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (lower_pixel),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_upper_q)
    );

    gef_sdp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_pixel),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_lower_q)
    );

    // A read of the column that is written in the same cycle returns stale data,
    // so the freshly written values are forwarded instead.
    assign byp_next = rd_en && wr_en && (rd_addr == AW'(wr_addr));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else if (rd_en) begin
            byp_reg <= byp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (byp_next) begin
            byp_upper_reg <= lower_pixel;
            byp_lower_reg <= wr_pixel;
        end
    end

    assign upper_pixel = byp_reg ? byp_upper_reg : ram_upper_q;
    assign lower_pixel = byp_reg ? byp_lower_reg : ram_lower_q;

endmodule

@@ design/gef_position.sv @@
`timescale 1ns / 1ps

module gef_position #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [gef_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gef_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              in_accept,
    input  logic                              in_op,
    input  gef_pkg::pix_t                     in_pixel,
    output logic                              rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr,
    output logic                              s1_active,
    output gef_pkg::step_ctrl_t               s1_ctrl,
    output gef_pkg::pix_t                     s1_pixel,
    output logic [$clog2(MAX_WIDTH)-1:0]      s1_col
);

    import gef_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    // The row count runs up to the height plus one while the last row drains.
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    logic [CFG_DATA_W-1:0] frame_width_reg;
    logic [CFG_DATA_W-1:0] frame_height_reg;
    logic [CW-1:0]         col_reg;
    logic [CW-1:0]         col_next;
    logic [RW-1:0]         row_reg;
    logic [RW-1:0]         row_next;

    logic                  s1_active_reg;
    step_ctrl_t            s1_ctrl_reg;
    step_ctrl_t            s1_ctrl_next;
    pix_t                  s1_pixel_reg;
    logic [CW-1:0]         s1_col_reg;

    logic [WW-1:0]         w_eff;
    logic [HW-1:0]         h_eff;
    logic [RW-1:0]         h_row;
    logic [CW-1:0]         col_c;
    logic [WW-1:0]         col_inc;
    logic                  drain_phase;
    logic                  active;
    logic                  size_write;

    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(frame_width_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            h_eff = HW'(1);
        end else if (32'(frame_height_reg) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(frame_height_reg);
        end
    end

    assign h_row       = RW'(h_eff);
    assign col_c       = (WW'(col_reg) >= w_eff) ? CW'(w_eff - WW'(1)) : col_reg;
    assign col_inc     = WW'(col_c) + WW'(1);
    assign drain_phase = row_reg >= h_row;
    // A drain beat before the whole frame has arrived changes nothing.
    assign active      = in_accept && !((in_op == OP_DRAIN) && !drain_phase);
    assign size_write  = cfg_wr_en
                         && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

    always_comb begin
        s1_ctrl_next.shift     = (col_c == '0) && (row_reg >= RW'(2));
        s1_ctrl_next.produce   = s1_ctrl_next.shift || ((col_c != '0) && (row_reg >= RW'(1)));
        s1_ctrl_next.frame_end = s1_ctrl_next.shift && (row_reg == h_row + RW'(1));
        if (s1_ctrl_next.shift) begin
            s1_ctrl_next.mask_top  = row_reg == RW'(2);
            s1_ctrl_next.mask_bot  = row_reg >= h_row + RW'(1);
            s1_ctrl_next.mask_left = w_eff == WW'(1);
        end else begin
            s1_ctrl_next.mask_top  = row_reg == RW'(1);
            s1_ctrl_next.mask_bot  = row_reg >= h_row;
            s1_ctrl_next.mask_left = col_c == CW'(1);
        end

        if (s1_ctrl_next.frame_end) begin
            col_next = '0;
            row_next = '0;
        end else if (col_inc >= w_eff) begin
            col_next = '0;
            row_next = row_reg + RW'(1);
        end else begin
            col_next = CW'(col_inc);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RESET_FRAME_WIDTH;
            frame_height_reg <= RESET_FRAME_HEIGHT;
            col_reg          <= '0;
            row_reg          <= '0;
            s1_active_reg    <= 1'b0;
        end else begin
            s1_active_reg <= active;
            if (cfg_wr_en && cfg_index == CFG_FRAME_WIDTH) begin
                frame_width_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_index == CFG_FRAME_HEIGHT) begin
                frame_height_reg <= cfg_wr_data;
            end
            if (size_write) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (active) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (active) begin
            s1_ctrl_reg  <= s1_ctrl_next;
            s1_pixel_reg <= drain_phase ? '0 : in_pixel;
            s1_col_reg   <= col_c;
        end
    end

    assign rd_en     = active;
    assign rd_addr   = col_c;
    assign s1_active = s1_active_reg;
    assign s1_ctrl   = s1_ctrl_reg;
    assign s1_pixel  = s1_pixel_reg;
    assign s1_col    = s1_col_reg;

endmodule

@@ design/gef_window.sv @@
`timescale 1ns / 1ps

module gef_window (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                operator_mode,
    input  logic                s1_active,
    input  gef_pkg::step_ctrl_t s1_ctrl,
    input  gef_pkg::pix_t       s1_pixel,
    input  gef_pkg::pix_t       upper_pixel,
    input  gef_pkg::pix_t       lower_pixel,
    output logic                res_push,
    output gef_pkg::result_t    res_data
);

    import gef_pkg::*;

    pix_t                     win_reg [3][3];
    pix_t                     vec     [3];
    pix_t                     tap     [3][3];
    logic signed [GRAD_W-1:0] dx      [3];
    logic signed [GRAD_W-1:0] dy      [3];
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [GRAD_W-1:0]        gx_abs;
    logic [GRAD_W-1:0]        gy_abs;
    logic [MAG_W-1:0]         mag_sum;

    assign vec[0] = upper_pixel;
    assign vec[1] = lower_pixel;
    assign vec[2] = s1_pixel;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            tap[k][0] = win_reg[k][1];
            tap[k][1] = win_reg[k][2];
            // The right neighbour of a row's last pixel lies outside the frame.
            tap[k][2] = s1_ctrl.shift ? '0 : vec[k];
        end
        for (int k = 0; k < 3; k++) begin
            for (int l = 0; l < 3; l++) begin
                if ((k == 0 && s1_ctrl.mask_top) || (k == 2 && s1_ctrl.mask_bot)
                        || (l == 0 && s1_ctrl.mask_left)) begin
                    tap[k][l] = '0;
                end
            end
        end
        for (int k = 0; k < 3; k++) begin
            dx[k] = $signed({3'b000, tap[k][2]}) - $signed({3'b000, tap[k][0]});
            dy[k] = $signed({3'b000, tap[2][k]}) - $signed({3'b000, tap[0][k]});
        end
        if (operator_mode == MODE_SOBEL) begin
            gx = dx[0] + (dx[1] <<< 1) + dx[2];
            gy = dy[0] + (dy[1] <<< 1) + dy[2];
        end else begin
            gx = dx[0] + dx[1] + dx[2];
            gy = dy[0] + dy[1] + dy[2];
        end
        gx_abs  = gx[GRAD_W-1] ? GRAD_W'(-gx) : GRAD_W'(gx);
        gy_abs  = gy[GRAD_W-1] ? GRAD_W'(-gy) : GRAD_W'(gy);
        mag_sum = MAG_W'(gx_abs) + MAG_W'(gy_abs);

        if (gx[GRAD_W-1]) begin
            res_data.grad_x = '0;
        end else if (gx > GRAD_W'(255)) begin
            res_data.grad_x = '1;
        end else begin
            res_data.grad_x = gx[PIX_W-1:0];
        end
        if (gy[GRAD_W-1]) begin
            res_data.grad_y = '0;
        end else if (gy > GRAD_W'(255)) begin
            res_data.grad_y = '1;
        end else begin
            res_data.grad_y = gy[PIX_W-1:0];
        end
        res_data.magnitude = (mag_sum > MAG_W'(255)) ? '1 : mag_sum[PIX_W-1:0];
        res_data.frame_end = s1_ctrl.frame_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                for (int l = 0; l < 3; l++) begin
                    win_reg[k][l] <= '0;
                end
            end
        end else if (s1_active) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k][0] <= win_reg[k][1];
                win_reg[k][1] <= win_reg[k][2];
                win_reg[k][2] <= vec[k];
            end
        end
    end

    assign res_push = s1_active && s1_ctrl.produce;

endmodule

@@ design/gef_out_fifo.sv @@
`timescale 1ns / 1ps

module gef_out_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  gef_pkg::result_t push_data,
    output logic             out_valid,
    input  logic             out_ready,
    output gef_pkg::result_t out_data,
    output logic [1:0]       level
);

    import gef_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] level_reg;
    logic [1:0] level_next;
    logic       pop;

    assign pop = out_valid && out_ready;

    always_comb begin
        level_next = level_reg;
        if (push && !pop) begin
            level_next = level_reg + 2'd1;
        end else if (pop && !push) begin
            level_next = level_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= '0;
        end else begin
            level_reg <= level_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = level_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign level     = level_reg;

endmodule

@@ design/gradient_edge_filter_3x3.sv @@
`timescale 1ns / 1ps

// 3x3 Sobel/Prewitt edge filter on a raster stream of 8-bit grayscale pixels.
// Input beats carry a pixel in s_axis_tdata with s_axis_tuser low, or a drain
// beat with s_axis_tuser high. Each output beat carries the clamped horizontal
// and vertical gradients and the clamped magnitude; m_axis_tlast marks the
// result of the frame's last pixel. Neighbors outside the frame count as zero.
// The result for a pixel appears once the stream has moved one row and one
// pixel past it; after the last pixel, width + 1 drain beats flush the rest.
// A pixel beat that arrives after the whole frame acts as a drain beat, and a
// drain beat inside the frame is taken and ignored.
// One beat is accepted per clock while s_axis_tready is high. A result leaves on
// m_axis from the output queue; the pipeline is a registered line-store read,
// window registers with combinational kernel logic, and a two-entry output queue.
// When the receiver stalls, s_axis_tready drops as soon as the queue and the
// beat in flight would fill it; no result is lost.
// Reset returns mode, width (640) and height (480) to defaults and starts a
// new frame; the line stores are not cleared, since border masking hides them.
// Configuration writes go in while the stream is idle; a size write restarts
// the frame.
module gradient_edge_filter_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [gef_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gef_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] pixel_value
    input  logic                           s_axis_tuser,   // [0] op
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [23:0]                    m_axis_tdata,   // [7:0] grad_x, [15:8] grad_y,
                                                           // [23:16] magnitude
    output logic                           m_axis_tlast
);

    import gef_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic          operator_mode_reg;
    logic          in_accept;
    logic          rd_en;
    logic [CW-1:0] rd_addr;
    logic          s1_active;
    step_ctrl_t    s1_ctrl;
    pix_t          s1_pixel;
    logic [CW-1:0] s1_col;
    pix_t          upper_pixel;
    pix_t          lower_pixel;
    logic          res_push;
    result_t       res_data;
    result_t       out_data;
    logic [1:0]    level;
    logic [2:0]    backlog;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            operator_mode_reg <= MODE_SOBEL;
        end else if (cfg_wr_en && cfg_index == CFG_OPERATOR_MODE) begin
            operator_mode_reg <= cfg_wr_data[0];
        end
    end

    // Queue entries still owed after this cycle: stored results plus the one in
    // flight, less the one leaving now. A new beat needs room for one more.
    assign backlog = 3'(level) + 3'(res_push) - 3'(m_axis_tvalid && m_axis_tready);
    assign s_axis_tready = backlog <= 3'd1;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    gef_position #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_position (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_accept   (in_accept),
        .in_op       (s_axis_tuser),
        .in_pixel    (s_axis_tdata),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .s1_active   (s1_active),
        .s1_ctrl     (s1_ctrl),
        .s1_pixel    (s1_pixel),
        .s1_col      (s1_col)
    );

    gef_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .wr_en       (s1_active),
        .wr_addr     (s1_col),
        .wr_pixel    (s1_pixel),
        .upper_pixel (upper_pixel),
        .lower_pixel (lower_pixel)
    );

    gef_window u_window (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .operator_mode (operator_mode_reg),
        .s1_active     (s1_active),
        .s1_ctrl       (s1_ctrl),
        .s1_pixel      (s1_pixel),
        .upper_pixel   (upper_pixel),
        .lower_pixel   (lower_pixel),
        .res_push      (res_push),
        .res_data      (res_data)
    );

    gef_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data),
        .level     (level)
    );

    assign m_axis_tdata = {out_data.magnitude, out_data.grad_y, out_data.grad_x};
    assign m_axis_tlast = out_data.frame_end;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

package edge_check_pkg;
    import gef_pkg::*;

    localparam int MAX_DIM = 1024;

    typedef pix_t window_t [3][3];

    // Keeps its own copy of the line stores, window and frame position, and
    // turns every accepted input beat into the results the filter owes.
    class edge_scoreboard;
        pix_t                  upper_row [MAX_DIM];
        pix_t                  lower_row [MAX_DIM];
        window_t               win;
        int                    col_pos;
        int                    row_pos;
        logic                  mode;
        logic [CFG_DATA_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0] height_reg;
        result_t               pending [$];
        int                    errors;

        function new();
            foreach (upper_row[i]) begin
                upper_row[i] = '0;
                lower_row[i] = '0;
            end
            foreach (win[k, l]) win[k][l] = '0;
            col_pos    = 0;
            row_pos    = 0;
            mode       = MODE_SOBEL;
            width_reg  = RESET_FRAME_WIDTH;
            height_reg = RESET_FRAME_HEIGHT;
            errors     = 0;
        endfunction

        function int clamp_dim(int v);
            if (v < 1) return 1;
            if (v > MAX_DIM) return MAX_DIM;
            return v;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_OPERATOR_MODE: mode = val[0];
                CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT: begin
                    if (idx == CFG_FRAME_WIDTH) width_reg = val;
                    else height_reg = val;
                    col_pos = 0;
                    row_pos = 0;
                end
                default: ;
            endcase
        endfunction

        function pix_t to_byte(int v);
            if (v < 0) return '0;
            if (v > 255) return 8'd255;
            return pix_t'(v);
        endfunction

        // Both kernel pairs are the same shape; only the weight of the center
        // row or column differs (2 for Sobel, 1 for Prewitt).
        function result_t grade(window_t t, int r, int c, int w, int h);
            int      gx;
            int      gy;
            int      mid;
            int      v;
            result_t res;
            gx  = 0;
            gy  = 0;
            mid = (mode == MODE_SOBEL) ? 2 : 1;
            for (int k = 0; k < 3; k++) begin
                for (int l = 0; l < 3; l++) begin
                    if ((k == 0 && r == 0) || (k == 2 && r + 1 >= h) ||
                        (l == 0 && c == 0) || (l == 2 && c + 1 >= w)) continue;
                    v  = int'(t[k][l]);
                    gx += v * (l - 1) * ((k == 1) ? mid : 1);
                    gy += v * (k - 1) * ((l == 1) ? mid : 1);
                end
            end
            res.grad_x    = to_byte(gx);
            res.grad_y    = to_byte(gy);
            res.magnitude = to_byte((gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy));
            res.frame_end = (r + 1 == h) && (c + 1 == w);
            return res;
        endfunction

        function void note_input(logic op, pix_t pixel);
            int      w;
            int      h;
            int      col;
            int      row;
            bit      flushing;
            bit      finished;
            pix_t    px;
            pix_t    fresh [3];
            window_t tail;
            result_t res;
            w        = clamp_dim(int'(width_reg));
            h        = clamp_dim(int'(height_reg));
            flushing = (row_pos >= h);
            // A drain beat while the frame is still arriving has no effect.
            if (op == OP_DRAIN && !flushing) return;
            col      = (col_pos >= w) ? w - 1 : col_pos;
            row      = row_pos;
            px       = flushing ? '0 : pixel;
            fresh[0] = upper_row[col];
            fresh[1] = lower_row[col];
            fresh[2] = px;
            finished = 1'b0;
            // At column zero the window still holds the end of the row before,
            // so the last pixel of that row is finished here.
            if (col == 0 && row >= 2) begin
                for (int k = 0; k < 3; k++) begin
                    tail[k][0] = win[k][1];
                    tail[k][1] = win[k][2];
                    tail[k][2] = '0;
                end
                res = grade(tail, row - 2, w - 1, w, h);
                pending.push_back(res);
                finished = res.frame_end;
            end
            for (int k = 0; k < 3; k++) begin
                win[k][0] = win[k][1];
                win[k][1] = win[k][2];
                win[k][2] = fresh[k];
            end
            if (col >= 1 && row >= 1) begin
                res = grade(win, row - 1, col - 1, w, h);
                pending.push_back(res);
                finished = res.frame_end;
            end
            upper_row[col] = lower_row[col];
            lower_row[col] = px;
            if (finished) begin
                col_pos = 0;
                row_pos = 0;
            end else begin
                col++;
                if (col >= w) begin
                    col = 0;
                    row++;
                end
                col_pos = col;
                row_pos = row;
            end
        endfunction

        task report(string msg);
            if (errors < 40) $display("MISMATCH at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [23:0] data, logic last);
            result_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected beat tdata=%h tlast=%b", data, last));
                return;
            end
            want = pending.pop_front();
            if (data[7:0] !== want.grad_x)
                report($sformatf("grad_x %0d, expected %0d", data[7:0], want.grad_x));
            if (data[15:8] !== want.grad_y)
                report($sformatf("grad_y %0d, expected %0d", data[15:8], want.grad_y));
            if (data[23:16] !== want.magnitude)
                report($sformatf("magnitude %0d, expected %0d", data[23:16], want.magnitude));
            if (last !== want.frame_end)
                report($sformatf("tlast %b, expected %b", last, want.frame_end));
        endtask
    endclass

endpackage

module tb_top;
    import gef_pkg::*;
    import edge_check_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 300;

    // Index past the last register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;
    logic                  m_axis_tlast;

    edge_scoreboard sb;
    int             tx_idle_pct;
    int             rx_idle_pct;
    int             idle_cycles;
    int             beat_count;
    bit             hold_req;

    gradient_edge_filter_3x3 dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    function void set_idle(int sel);
        case (sel % 4)
            0: begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            1: begin
                tx_idle_pct = 70;
                rx_idle_pct = 0;
            end
            2: begin
                tx_idle_pct = 0;
                rx_idle_pct = 70;
            end
            default: begin
                tx_idle_pct = 20;
                rx_idle_pct = 20;
            end
        endcase
    endfunction

    // Flat pixels often saturate nothing, so the extremes are drawn often.
    function pix_t rand_pixel();
        case ($urandom_range(3, 0))
            0: return '0;
            1: return 8'd255;
            default: return pix_t'($urandom_range(255, 0));
        endcase
    endfunction

    task automatic send_beat(input logic op, input pix_t px);
        @(negedge aclk);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = px;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_input(op, px);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = val;
        @(posedge aclk);
        sb.apply_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Stop offering beats and wait until every owed result has come back,
    // plus SETTLE_CYCLES more for beats that produce nothing but are still in flight.
    task automatic settle();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // A negative stop_at sends the whole frame and its w+1 flush beats;
    // otherwise the frame is abandoned after stop_at pixels.
    task automatic stream_frame(input int w, input int h, input int stop_at);
        int pixels;
        pixels = (stop_at >= 0) ? stop_at : w * h;
        for (int i = 0; i < pixels; i++) begin
            if ($urandom_range(99, 0) < 4) send_beat(OP_DRAIN, rand_pixel());
            send_beat(OP_PIXEL, rand_pixel());
            beat_count++;
        end
        if (stop_at < 0) begin
            for (int i = 0; i <= w; i++) begin
                send_beat(($urandom_range(3, 0) == 0) ? OP_PIXEL : OP_DRAIN, rand_pixel());
                beat_count++;
            end
            if ($urandom_range(7, 0) == 0) send_beat(OP_DRAIN, rand_pixel());
        end
    endtask

    // Receiver side; a hold request keeps tready low for a long stretch.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req      = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_axis_tready = ($urandom_range(99, 0) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
        if (!aresetn || cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        pix_t                  corner_pat [9];
        int                    cur_w;
        int                    cur_h;
        int                    w;
        int                    h;
        int                    phase;
        int                    sel;
        bit                    need_restart;
        sb            = new();
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_OPERATOR_MODE;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_PIXEL;
        hold_req      = 1'b0;
        beat_count    = 0;
        set_idle(0);
        corner_pat = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0};
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: a 3x3 Sobel frame with a stray drain inside it, a pixel
        // past the frame that must flush like a drain, and a drain after the
        // frame has ended.
        write_reg(CFG_OPERATOR_MODE, CFG_DATA_W'(MODE_SOBEL));
        write_reg(CFG_FRAME_WIDTH, 11'd3);
        write_reg(CFG_FRAME_HEIGHT, 11'd3);
        for (int i = 0; i < 9; i++) begin
            send_beat(OP_PIXEL, corner_pat[i]);
            if (i == 4) send_beat(OP_DRAIN, 8'hFF);
        end
        send_beat(OP_PIXEL, 8'h5A);
        repeat (3) send_beat(OP_DRAIN, 8'h00);
        send_beat(OP_DRAIN, 8'hA5);
        settle();

        // Prewitt on a single pixel frame and on a 2x2 frame, after a write to the unused index.
        write_reg(CFG_OPERATOR_MODE, CFG_DATA_W'(MODE_PREWITT));
        write_reg(CFG_UNUSED, 11'h7FF);
        write_reg(CFG_FRAME_WIDTH, 11'd1);
        write_reg(CFG_FRAME_HEIGHT, 11'd1);
        send_beat(OP_PIXEL, 8'hFF);
        repeat (2) send_beat(OP_DRAIN, 8'h00);
        settle();
        write_reg(CFG_FRAME_WIDTH, 11'd2);
        write_reg(CFG_FRAME_HEIGHT, 11'd2);
        send_beat(OP_PIXEL, 8'hFF);
        send_beat(OP_PIXEL, 8'h00);
        send_beat(OP_PIXEL, 8'h00);
        send_beat(OP_PIXEL, 8'hFF);
        repeat (3) send_beat(OP_DRAIN, 8'h00);
        settle();

        // Oversized width acts as the maximum; the frame is abandoned six
        // pixels into its second row, so the first results cover the top row.
        set_idle(3);
        write_reg(CFG_OPERATOR_MODE, CFG_DATA_W'(MODE_PREWITT));
        write_reg(CFG_FRAME_WIDTH, 11'h7FF);
        write_reg(CFG_FRAME_HEIGHT, 11'd2);
        stream_frame(1024, 2, 1030);
        settle();

        // One pixel wide, tall frame (0 width acts as 1). The receiver holds
        // off for a long stretch while beats keep coming, so the input side
        // must stall.
        set_idle(0);
        write_reg(CFG_OPERATOR_MODE, CFG_DATA_W'(MODE_SOBEL));
        write_reg(CFG_FRAME_WIDTH, 11'd0);
        write_reg(CFG_FRAME_HEIGHT, 11'h7FF);
        @(posedge aclk);
        hold_req = 1'b1;
        stream_frame(1, 1024, 200);
        settle();

        // Random frames, mostly small, with back-to-back frames, restarts
        // by size writes, and abandoned frames.
        beat_count   = 0;
        phase        = 0;
        need_restart = 1'b1;
        cur_w        = 0;
        cur_h        = 0;
        while (beat_count < RANDOM_ITEMS) begin
            set_idle(phase);
            phase++;
            write_reg(CFG_OPERATOR_MODE, CFG_DATA_W'($urandom_range(1, 0)));
            if (need_restart || $urandom_range(2, 0) == 0) begin
                sel = (beat_count == 0) ? 2 : $urandom_range(2, 0);
                if (sel != 1) begin
                    cur_w = ($urandom_range(19, 0) == 0) ? 0 : $urandom_range(12, 1);
                    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(cur_w));
                end
                if (sel != 0) begin
                    cur_h = ($urandom_range(19, 0) == 0) ? 0 : $urandom_range(8, 1);
                    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(cur_h));
                end
                need_restart = 1'b0;
            end
            w = sb.clamp_dim(cur_w);
            h = sb.clamp_dim(cur_h);
            repeat ($urandom_range(3, 1)) begin
                if ($urandom_range(9, 0) == 0) begin
                    stream_frame(w, h, $urandom_range(w * h - 1, 0));
                    need_restart = 1'b1;
                    break;
                end
                stream_frame(w, h, -1);
            end
            settle();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
